/* rtl/core/kt2d_pkg.sv */
package kt2d_pkg;
   localparam logic signed [63:0] COV_INIT = 64'sd1000 <<< 32;
   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [2:0] {
      REG_TIME_STEP  = 3'd0,
      REG_LOST_LIMIT = 3'd1,
      REG_NOISE_PP   = 3'd2,
      REG_NOISE_PV   = 3'd3,
      REG_NOISE_VV   = 3'd4,
      REG_MEAS_NOISE = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic [5:0]         sh;
   } mul_req_type;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
      else sat_add = s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
      else sat_sub = s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh000000007fffffff) sat32 = 32'sh7fffffff;
      else if (x < -64'sh0000000080000000) sat32 = 32'sh80000000;
      else sat32 = x[31:0];
   endfunction

   function automatic logic signed [63:0] clamp_reg(input logic [63:0] r);
      clamp_reg = r[63] ? S64_MAX : $signed(r);
   endfunction

   function automatic logic [63:0] mag(input logic signed [63:0] x);
      mag = x[63] ? 64'd0 - x : x;
   endfunction

   function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg,
                                                   input logic over);
      if (over || m[63]) with_sign = neg ? S64_MIN : S64_MAX;
      else with_sign = neg ? -$signed(m) : $signed(m);
   endfunction
endpackage

/* rtl/core/kt2d_req_if.sv */
interface kt2d_req_if;
   logic        valid;
   logic        ready;
   logic        meas_valid;
   logic [31:0] meas_x;
   logic [31:0] meas_y;
   modport source (output valid, meas_valid, meas_x, meas_y, input ready);
   modport sink (input valid, meas_valid, meas_x, meas_y, output ready);
endinterface

/* rtl/core/kt2d_rsp_if.sv */
interface kt2d_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pred_pos_x;
   logic [31:0] pred_vel_x;
   logic [31:0] pred_pos_y;
   logic [31:0] pred_vel_y;
   logic        track_valid;
   modport source (output valid, pred_pos_x, pred_vel_x, pred_pos_y, pred_vel_y,
                   track_valid, input ready);
   modport sink (input valid, pred_pos_x, pred_vel_x, pred_pos_y, pred_vel_y,
                 track_valid, output ready);
endinterface

/* rtl/core/kalman_tracker_2d_const_velocity_core.sv */
// two-axis constant-velocity kalman tracker, one frame per req transfer
// req channel: meas_valid, meas_x, meas_y (signed q16.16); a frame without a
// valid measurement counts a miss, and lost_limit misses drop the track
// rsp channel: one transfer per frame with predicted position and velocity of
// both axes and track_valid; with no track the last prediction is repeated
// csr port: write enable, index and 64-bit data; the user must write it only
// while the block is idle, unenforced by the block; index beyond 5 is ignored
// a frame with an active track runs both axes through one shared 64x64
// multiplier (nine products per axis) and one bit-serial divider (two
// quotients per axis); rsp.valid is set as S_NEXT finishes the second axis,
// or as S_CHECK finds that the frame leaves no track
// one frame at a time: req.ready stays low until the result has been taken,
// so a new frame is accepted only after rsp.ready has taken the previous one
// reset clears the track, miss count, state and covariance and loads the
// register defaults; a stalled rsp simply holds its result and req.ready
module kalman_tracker_2d_const_velocity_core
   import kt2d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kt2d_req_if.sink    req,
   kt2d_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_E_MUL, S_E, S_A0_MUL, S_A0, S_A1_MUL, S_A1, S_PP_MUL, S_PP,
      S_K0_DIV, S_K0, S_K1_DIV, S_K1, S_X_MUL, S_X, S_V_MUL, S_V, S_CA_MUL, S_CA,
      S_CB_MUL, S_CB, S_CC_MUL, S_CC, S_NEXT, S_OUT
   } state_type;

   state_type state_ff;
   logic [31:0] time_step_ff;
   logic [15:0] lost_limit_ff;
   logic [63:0] noise_pp_ff, noise_pv_ff, noise_vv_ff, meas_noise_ff;
   logic        found_ff;
   logic [15:0] miss_ff;
   logic signed [31:0] held_ff [2];
   logic signed [31:0] pos_ff [2];
   logic signed [31:0] vel_ff [2];
   logic signed [63:0] ca_ff [2];
   logic signed [63:0] cb_ff [2];
   logic signed [63:0] cc_ff [2];
   logic signed [31:0] pred_pos_ff [2];
   logic signed [31:0] pred_vel_ff [2];
   logic        axis_ff;
   logic signed [63:0] e_ff, a1_ff, b1_ff, c1_ff, s_ff, k0_ff, k1_ff, inn_ff;
   logic signed [31:0] pp_ff;
   logic        mul_start, div_start, mul_done, div_done;
   mul_req_type mul_req;
   logic signed [63:0] mul_res, div_res, div_num;
   logic signed [63:0] dt_s;
   logic        rsp_valid_ff;
   logic        req_xfer;

   assign dt_s = {32'd0, time_step_ff};
   assign req_xfer = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !reset;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.pred_pos_x = pred_pos_ff[0];
   assign rsp.pred_vel_x = pred_vel_ff[0];
   assign rsp.pred_pos_y = pred_pos_ff[1];
   assign rsp.pred_vel_y = pred_vel_ff[1];
   assign rsp.track_valid = found_ff;

   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      mul_req.a = dt_s;
      mul_req.b = '0;
      mul_req.sh = 6'd16;
      div_num = a1_ff;
      case (state_ff)
         S_E_MUL: begin
            mul_start = 1'b1;
            mul_req.b = cc_ff[axis_ff];
         end
         S_A0_MUL: begin
            mul_start = 1'b1;
            mul_req.b = cb_ff[axis_ff];
         end
         S_A1_MUL: begin
            mul_start = 1'b1;
            mul_req.b = e_ff;
         end
         S_PP_MUL: begin
            mul_start = 1'b1;
            mul_req.b = {{32{vel_ff[axis_ff][31]}}, vel_ff[axis_ff]};
         end
         S_K0_DIV: div_start = 1'b1;
         S_K1_DIV: begin
            div_start = 1'b1;
            div_num = b1_ff;
         end
         S_X_MUL: begin
            mul_start = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = inn_ff;
            mul_req.sh = 6'd32;
         end
         S_V_MUL: begin
            mul_start = 1'b1;
            mul_req.a = k1_ff;
            mul_req.b = inn_ff;
            mul_req.sh = 6'd32;
         end
         S_CA_MUL: begin
            mul_start = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = a1_ff;
            mul_req.sh = 6'd32;
         end
         S_CB_MUL: begin
            mul_start = 1'b1;
            mul_req.a = k0_ff;
            mul_req.b = b1_ff;
            mul_req.sh = 6'd32;
         end
         S_CC_MUL: begin
            mul_start = 1'b1;
            mul_req.a = k1_ff;
            mul_req.b = b1_ff;
            mul_req.sh = 6'd32;
         end
         default: ;
      endcase
   end

   kt2d_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .req    (mul_req),
      .done   (mul_done),
      .result (mul_res)
   );

   kt2d_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (s_ff),
      .done   (div_done),
      .result (div_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         time_step_ff <= 32'd1311;
         lost_limit_ff <= 16'd100;
         noise_pp_ff <= 64'd4295;
         noise_pv_ff <= 64'd429497;
         noise_vv_ff <= 64'd42949673;
         meas_noise_ff <= 64'd107374182400;
         found_ff <= 1'b0;
         miss_ff <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            held_ff[i] <= '0;
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            ca_ff[i] <= '0;
            cb_ff[i] <= '0;
            cc_ff[i] <= '0;
            pred_pos_ff[i] <= '0;
            pred_vel_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_TIME_STEP: time_step_ff <= csr_data[31:0];
               REG_LOST_LIMIT: lost_limit_ff <= csr_data[15:0];
               REG_NOISE_PP: noise_pp_ff <= csr_data;
               REG_NOISE_PV: noise_pv_ff <= csr_data;
               REG_NOISE_VV: noise_vv_ff <= csr_data;
               REG_MEAS_NOISE: meas_noise_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  if (req.meas_valid) begin
                     held_ff[0] <= req.meas_x;
                     held_ff[1] <= req.meas_y;
                     miss_ff <= '0;
                     if (!found_ff) begin
                        pos_ff[0] <= req.meas_x;
                        pos_ff[1] <= req.meas_y;
                        for (int i = 0; i < 2; i++) begin
                           vel_ff[i] <= '0;
                           ca_ff[i] <= COV_INIT;
                           cb_ff[i] <= '0;
                           cc_ff[i] <= COV_INIT;
                        end
                     end
                     found_ff <= 1'b1;
                  end else if (miss_ff != 16'hffff) begin
                     miss_ff <= miss_ff + 16'd1;
                  end
                  axis_ff <= 1'b0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (miss_ff >= lost_limit_ff) begin
                  found_ff <= 1'b0;
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end else if (found_ff) begin
                  state_ff <= S_E_MUL;
               end else begin
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_E_MUL: state_ff <= S_E;
            S_E: if (mul_done) begin
               e_ff <= sat_add(cb_ff[axis_ff], mul_res);
               state_ff <= S_A0_MUL;
            end
            S_A0_MUL: state_ff <= S_A0;
            S_A0: if (mul_done) begin
               a1_ff <= sat_add(ca_ff[axis_ff], mul_res);
               b1_ff <= sat_add(e_ff, clamp_reg(noise_pv_ff));
               c1_ff <= sat_add(cc_ff[axis_ff], clamp_reg(noise_vv_ff));
               state_ff <= S_A1_MUL;
            end
            S_A1_MUL: state_ff <= S_A1;
            S_A1: if (mul_done) begin
               a1_ff <= sat_add(sat_add(a1_ff, mul_res), clamp_reg(noise_pp_ff));
               state_ff <= S_PP_MUL;
            end
            S_PP_MUL: begin
               s_ff <= sat_add(a1_ff, clamp_reg(meas_noise_ff));
               state_ff <= S_PP;
            end
            S_PP: if (mul_done) begin
               pp_ff <= sat32(sat_add({{32{pos_ff[axis_ff][31]}}, pos_ff[axis_ff]}, mul_res));
               state_ff <= S_K0_DIV;
            end
            S_K0_DIV: begin
               pred_pos_ff[axis_ff] <= pp_ff;
               pred_vel_ff[axis_ff] <= vel_ff[axis_ff];
               inn_ff <= {{32{held_ff[axis_ff][31]}}, held_ff[axis_ff]}
                         - {{32{pp_ff[31]}}, pp_ff};
               state_ff <= S_K0;
            end
            S_K0: if (div_done) begin
               k0_ff <= div_res;
               state_ff <= S_K1_DIV;
            end
            S_K1_DIV: state_ff <= S_K1;
            S_K1: if (div_done) begin
               k1_ff <= div_res;
               state_ff <= S_X_MUL;
            end
            S_X_MUL: state_ff <= S_X;
            S_X: if (mul_done) begin
               pos_ff[axis_ff] <= sat32(sat_add({{32{pp_ff[31]}}, pp_ff}, mul_res));
               state_ff <= S_V_MUL;
            end
            S_V_MUL: state_ff <= S_V;
            S_V: if (mul_done) begin
               vel_ff[axis_ff] <= sat32(sat_add({{32{vel_ff[axis_ff][31]}},
                                                 vel_ff[axis_ff]}, mul_res));
               state_ff <= S_CA_MUL;
            end
            S_CA_MUL: state_ff <= S_CA;
            S_CA: if (mul_done) begin
               ca_ff[axis_ff] <= sat_sub(a1_ff, mul_res);
               state_ff <= S_CB_MUL;
            end
            S_CB_MUL: state_ff <= S_CB;
            S_CB: if (mul_done) begin
               cb_ff[axis_ff] <= sat_sub(b1_ff, mul_res);
               state_ff <= S_CC_MUL;
            end
            S_CC_MUL: state_ff <= S_CC;
            S_CC: if (mul_done) begin
               cc_ff[axis_ff] <= sat_sub(c1_ff, mul_res);
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (axis_ff) begin
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  axis_ff <= 1'b1;
                  state_ff <= S_E_MUL;
               end
            end
            S_OUT: if (rsp.ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/core/kt2d_mul.sv */
module kt2d_mul
   import kt2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mul_req_type        req,
   output logic               done,
   output logic signed [63:0] result
);
   // 64x64 magnitude product from four 32x32 partial products, one per cycle
   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic         neg_ff, neg_in;
   logic [5:0]   sh_ff, sh_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   step_ff, step_in;
   logic         busy_ff, busy_in;
   logic [63:0]  pp;
   logic [127:0] pp_ext;
   logic [127:0] shifted;
   logic [63:0]  hi_part;

   always_comb begin
      case (step_ff[1:0])
         2'd0: pp = x_ff[31:0] * y_ff[31:0];
         2'd1: pp = x_ff[31:0] * y_ff[63:32];
         2'd2: pp = x_ff[63:32] * y_ff[31:0];
         default: pp = x_ff[63:32] * y_ff[63:32];
      endcase
      case (step_ff[1:0])
         2'd0: pp_ext = {64'd0, pp};
         2'd1, 2'd2: pp_ext = {32'd0, pp, 32'd0};
         default: pp_ext = {pp, 64'd0};
      endcase
      shifted = acc_ff >> sh_ff;
      hi_part = acc_ff[127:64] >> sh_ff;
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      neg_in = neg_ff;
      sh_in = sh_ff;
      acc_in = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         x_in = mag(req.a);
         y_in = mag(req.b);
         neg_in = req.a[63] ^ req.b[63];
         sh_in = req.sh;
         acc_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + pp_ext;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd3) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      neg_ff <= neg_in;
      sh_ff <= sh_in;
      acc_ff <= acc_in;
      step_ff <= step_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = !busy_ff && !start;
   assign result = with_sign(shifted[63:0], neg_ff, hi_part != 64'd0);
endmodule

/* rtl/core/kt2d_div.sv */
module kt2d_div
   import kt2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [63:0] result
);
   // restoring division, one quotient bit per cycle over 128 dividend bits
   logic [127:0] n_ff, n_in;
   logic [63:0]  d_ff, d_in, rem_ff, rem_in, q_ff, q_in;
   logic         neg_ff, neg_in, over_ff, over_in, zero_ff, zero_in, busy_ff, busy_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [64:0]  rem_sh;
   logic [64:0]  diff;

   always_comb begin
      rem_sh = {rem_ff, n_ff[127]};
      diff = rem_sh - {1'b0, d_ff};
      n_in = n_ff;
      d_in = d_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      over_in = over_ff;
      zero_in = zero_ff;
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      if (start) begin
         n_in = {32'd0, mag(num), 32'd0};
         d_in = mag(den);
         rem_in = '0;
         q_in = '0;
         neg_in = num[63] ^ den[63];
         over_in = 1'b0;
         zero_in = den == 64'sd0;
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         n_in = n_ff << 1;
         if (q_ff[63]) over_in = 1'b1;
         if (!diff[64]) begin
            rem_in = diff[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[63:0];
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      d_ff <= d_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      neg_ff <= neg_in;
      over_ff <= over_in;
      zero_ff <= zero_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = !busy_ff && !start;
   assign result = zero_ff ? 64'sd0 : with_sign(q_ff, neg_ff, over_ff);
endmodule
